@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the quota filter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/pieqf_pkg.sv @@
// Shared types, sizes and codes for the per-input event quota filter.
// No dependencies; imported by the lane, merge and top-level modules.
`default_nettype none

package pieqf_pkg;

    localparam int NUM_INPUTS = 15;
    localparam int CNT_W      = 31;
    localparam int MASK_W     = 15;
    localparam int IDX_W      = 4;
    localparam int SEL_N      = 2 ** IDX_W;
    localparam int GRP        = 4;
    localparam int NGRP       = (NUM_INPUTS + GRP - 1) / GRP;
    localparam int PAD_N      = NGRP * GRP;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;
    localparam int DATA_W     = 32;

    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t CNT_MAX = '1;
    localparam cnt_t CNT_ONE = cnt_t'(1);

    typedef enum logic [1:0] {
        CMD_EVENT = 2'd0,
        CMD_INIT  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    localparam logic [REG_IDX_W-1:0] REG_REQUESTED = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MASKED    = REG_IDX_W'(1);

    // Payload that rides alongside the lowest-count tree.
    typedef struct packed {
        logic needed;
        logic armed;
        cnt_t kept;
        cnt_t sel;
    } stage_t;

    function automatic cnt_t min2(input cnt_t a, input cnt_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pieqf_lane.sv @@
// One per-input saturating counter with its quota compare.
// Depends on pieqf_pkg.
`default_nettype none

module pieqf_lane
    import pieqf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire cmd_t  cmd,
    input  wire logic  nonempty,
    input  wire logic  excluded,
    input  wire cnt_t  quota,
    input  wire logic  keep,
    output logic       hit,
    output cnt_t       count_next
);

    cnt_t count_reg;
    logic active;

    assign active = nonempty & ~excluded;

    // Flag this input as still short of its quota
    assign hit = active & (count_reg < quota);

    // Clear on initialize or reset, bump on a kept event
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            case (cmd) inside
                CMD_INIT, CMD_RESET:
                begin
                    count_next = '0;
                end
                CMD_EVENT:
                begin
                    if (keep && active && (count_reg != CNT_MAX))
                        count_next = count_reg + CNT_ONE;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pieqf_merge.sv @@
// Two-level registered minimum tree over the lane candidates plus output register.
// Depends on pieqf_pkg.
`default_nettype none

module pieqf_merge
    import pieqf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s1_valid,
    input  wire stage_t               s1_data,
    input  wire logic [PAD_N-1:0][CNT_W-1:0] s1_cand,
    output logic                      s2_take,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      needed,
    output logic [CNT_W-1:0]          lowest_count,
    output logic [CNT_W-1:0]          kept_events,
    output logic [CNT_W-1:0]          selected_count
);

    logic                s2_valid_reg;
    logic                s2_valid_next;
    stage_t              s2_data_reg;
    cnt_t [NGRP-1:0]     grp_min_reg;
    cnt_t [NGRP-1:0]     grp_min_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    stage_t              out_data_reg;
    cnt_t                lowest_reg;
    cnt_t                lowest_next;
    logic                out_ready;
    logic                s2_load;
    logic                out_load;

    // Advance each stage when the one after it is empty or draining
    assign out_ready = ~out_valid_reg | ~out_stall;
    assign s2_take   = ~s2_valid_reg | out_ready;
    assign s2_load   = s1_valid & s2_take;
    assign out_load  = s2_valid_reg & out_ready;

    // First tree level: minimum inside each group of four lanes
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_min_next[g] = CNT_MAX;
            for (int k = 0; k < GRP; k++)
                grp_min_next[g] = min2(grp_min_next[g], s1_cand[g*GRP + k]);
        end
    end

    // Second tree level: minimum across groups, forced to zero when disarmed
    always_comb
    begin
        lowest_next = CNT_MAX;
        for (int g = 0; g < NGRP; g++)
            lowest_next = min2(lowest_next, grp_min_reg[g]);
        if (!s2_data_reg.armed)
            lowest_next = '0;
    end

    assign s2_valid_next  = s2_load | (s2_valid_reg & ~out_ready);
    assign out_valid_next = out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers unless their stage loads
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_data_reg <= s1_data;
            grp_min_reg <= grp_min_next;
        end
        if (out_load)
        begin
            out_data_reg <= s2_data_reg;
            lowest_reg   <= lowest_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign needed         = out_data_reg.needed;
    assign lowest_count   = lowest_reg;
    assign kept_events    = out_data_reg.kept;
    assign selected_count = out_data_reg.sel;

endmodule

`default_nettype wire

@@ hw/rtl/per_input_event_quota_filter.sv @@
// Top level of the per-input event quota filter: register port, lanes, stage one.
// Depends on pieqf_pkg, pieqf_lane, pieqf_merge and assert_macros.svh.
//
//   Port group   Handshake            Moves
//   -----------  -------------------  ------------------------------------------
//   config       psel/penable/pready  requested_events, masked_inputs (APB)
//   input        in_valid/in_stall    command, header_bits, input_index
//   output       out_valid/out_stall  needed, lowest_count, kept_events,
//                                     selected_count
//
// One item is taken every cycle while in_stall is low; results pass s1, s2, output.
// Counters update in the accept cycle; a two-level registered min tree follows.
// Reset clears counters, live mask, total, armed flag and both registers.
// A stalled output backs up the pipeline stage by stage before in_stall rises.
`default_nettype none

`include "assert_macros.svh"

module per_input_event_quota_filter
    import pieqf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        command,
    input  wire logic [MASK_W-1:0] header_bits,
    input  wire logic [IDX_W-1:0]  input_index,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   needed,
    output logic [CNT_W-1:0]       lowest_count,
    output logic [CNT_W-1:0]       kept_events,
    output logic [CNT_W-1:0]       selected_count
);

    cnt_t                    requested_reg;
    logic [MASK_W-1:0]       masked_reg;
    logic [MASK_W-1:0]       live_reg;
    logic [MASK_W-1:0]       live_next;
    cnt_t                    total_reg;
    cnt_t                    total_next;
    logic                    armed_reg;
    logic                    armed_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    stage_t                  s1_data_reg;
    stage_t                  s1_data_next;
    logic [PAD_N-1:0][CNT_W-1:0] cand_reg;
    logic [PAD_N-1:0][CNT_W-1:0] cand_next;
    cnt_t [SEL_N-1:0]        sel_arr;
    cnt_t [NUM_INPUTS-1:0]   cnt_next;
    logic [NUM_INPUTS-1:0]   lane_hit;
    logic [NUM_INPUTS-1:0]   lane_ne;
    logic [NUM_INPUTS-1:0]   lane_mask;
    logic [NUM_INPUTS-1:0]   lane_live;
    cmd_t                    cmd;
    logic                    in_accept;
    logic                    keep;
    logic                    s2_take;
    logic                    cfg_write;
    logic [REG_IDX_W-1:0]    reg_idx;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_reg <= '0;
            masked_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_REQUESTED: requested_reg <= pwdata[CNT_W-1:0];
                REG_MASKED:    masked_reg    <= pwdata[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_REQUESTED: prdata = DATA_W'(requested_reg);
            REG_MASKED:    prdata = DATA_W'(masked_reg);
            default:       prdata = '0;
        endcase
    end

    // Input handshake
    assign cmd       = cmd_t'(command);
    assign in_stall  = s1_valid_reg & ~s2_take;
    assign in_accept = in_valid & ~in_stall;

    // Map header and mask bits onto lanes; lanes past the mask width stay idle
    for (genvar i = 0; i < NUM_INPUTS; i++)
    begin : g_map
        if (i < MASK_W)
        begin : g_bit
            assign lane_ne[i]   = header_bits[i];
            assign lane_mask[i] = masked_reg[i];
            assign lane_live[i] = live_next[i];
        end
        else
        begin : g_nobit
            assign lane_ne[i]   = 1'b0;
            assign lane_mask[i] = 1'b0;
            assign lane_live[i] = 1'b0;
        end
    end

    // Keep the event if armed and any active lane is short of quota
    assign keep = armed_reg & (cmd == CMD_EVENT) & (|lane_hit);

    for (genvar i = 0; i < NUM_INPUTS; i++)
    begin : g_lane
        pieqf_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (in_accept),
            .cmd        (cmd),
            .nonempty   (lane_ne[i]),
            .excluded   (lane_mask[i]),
            .quota      (requested_reg),
            .keep       (keep),
            .hit        (lane_hit[i]),
            .count_next (cnt_next[i])
        );
    end

    // Run-level state: armed flag, live mask, kept total
    always_comb
    begin
        armed_next = armed_reg;
        live_next  = live_reg;
        total_next = total_reg;
        if (in_accept)
        begin
            case (cmd)
                CMD_INIT:
                begin
                    armed_next = 1'b1;
                    live_next  = header_bits;
                    total_next = '0;
                end
                CMD_RESET:
                begin
                    armed_next = 1'b0;
                    live_next  = '0;
                    total_next = '0;
                end
                CMD_EVENT:
                begin
                    if (keep && (total_reg != CNT_MAX))
                        total_next = total_reg + CNT_ONE;
                end
                default:
                begin
                    total_next = total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            live_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            live_reg  <= live_next;
            total_reg <= total_next;
        end
    end

    // Stage one: post-update snapshot of candidates and selected counter
    always_comb
    begin
        sel_arr   = '0;
        cand_next = '1;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            sel_arr[i] = cnt_next[i];
            if (lane_live[i] && !lane_mask[i])
                cand_next[i] = cnt_next[i];
        end
    end

    always_comb
    begin
        s1_data_next.needed = keep;
        s1_data_next.armed  = armed_next;
        s1_data_next.kept   = total_next;
        s1_data_next.sel    = (32'(input_index) < NUM_INPUTS) ? sel_arr[input_index] : '0;
    end

    assign s1_valid_next = in_accept | (s1_valid_reg & ~s2_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= s1_data_next;
            cand_reg    <= cand_next;
        end
    end

    // Merge: min tree and output register
    pieqf_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid_reg),
        .s1_data        (s1_data_reg),
        .s1_cand        (cand_reg),
        .s2_take        (s2_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .needed         (needed),
        .lowest_count   (lowest_count),
        .kept_events    (kept_events),
        .selected_count (selected_count)
    );

    // Checks
    `ASSERT_SAME(a_keep_armed, clk, rst_n, keep, armed_reg)
    `ASSERT_NEXT(a_keep_total, clk, rst_n, in_accept && keep, total_reg != '0)
    `ASSERT_NEXT(a_init_arms, clk, rst_n, in_accept && (cmd == CMD_INIT), armed_reg)
    `ASSERT_SAME(a_out_kept, clk, rst_n, out_valid && needed, kept_events != '0)

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for per_input_event_quota_filter.
// Needs pieqf_pkg and the filter RTL; covers register access, directed quota cases
// and random event runs, some with the valid/stall handshakes idling at random.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pieqf_pkg::*;

    localparam int  RESET_CYCLES = 7;
    localparam int  DRAIN_CYCLES = 6;
    localparam cnt_t CNT_ZERO    = '0;
    localparam logic [MASK_W-1:0] ALL_INPUTS = '1;
    localparam logic [MASK_W-1:0] NO_INPUTS  = '0;

    typedef struct packed {
        logic needed;
        cnt_t lowest;
        cnt_t kept;
        cnt_t sel;
    } quota_report_t;

    // Block ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    cmd_t              command = CMD_QUERY;
    logic [MASK_W-1:0] header_bits = '0;
    logic [IDX_W-1:0]  input_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              needed;
    logic [CNT_W-1:0]  lowest_count;
    logic [CNT_W-1:0]  kept_events;
    logic [CNT_W-1:0]  selected_count;

    // Shadow of the filter state and its registers
    cnt_t              quota_reg = '0;
    logic [MASK_W-1:0] mask_reg = '0;
    cnt_t              input_counts [NUM_INPUTS];
    logic [MASK_W-1:0] live_mask = '0;
    cnt_t              kept_total = '0;
    logic              run_armed = 1'b0;

    quota_report_t     pending_reports [$];
    int                mismatch_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    per_input_event_quota_filter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .header_bits    (header_bits),
        .input_index    (input_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .needed         (needed),
        .lowest_count   (lowest_count),
        .kept_events    (kept_events),
        .selected_count (selected_count)
    );

    always #5 clk = ~clk;

    // Stall the output side at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Apply one item to the shadow state and return the report it yields
    function automatic quota_report_t count_item(input cmd_t cmd,
                                                 input logic [MASK_W-1:0] hdr,
                                                 input logic [IDX_W-1:0] idx);
        quota_report_t rep;
        logic          keep;
        cnt_t          low;
        keep = 1'b0;
        case (cmd)
            CMD_EVENT:
            begin
                if (run_armed)
                begin
                    for (int i = 0; i < NUM_INPUTS; i++)
                        if (hdr[i] && !mask_reg[i] && input_counts[i] < quota_reg)
                            keep = 1'b1;
                    if (keep)
                    begin
                        for (int i = 0; i < NUM_INPUTS; i++)
                            if (hdr[i] && !mask_reg[i] && input_counts[i] != CNT_MAX)
                                input_counts[i] = input_counts[i] + CNT_ONE;
                        if (kept_total != CNT_MAX)
                            kept_total = kept_total + CNT_ONE;
                    end
                end
            end
            CMD_INIT, CMD_RESET:
            begin
                live_mask = (cmd == CMD_INIT) ? hdr : NO_INPUTS;
                run_armed = (cmd == CMD_INIT);
                kept_total = CNT_ZERO;
                for (int i = 0; i < NUM_INPUTS; i++)
                    input_counts[i] = CNT_ZERO;
            end
            default: ;
        endcase
        // lowest count over live unmasked inputs; zero while disarmed
        low = run_armed ? CNT_MAX : CNT_ZERO;
        if (run_armed)
            for (int i = 0; i < NUM_INPUTS; i++)
                if (live_mask[i] && !mask_reg[i] && input_counts[i] < low)
                    low = input_counts[i];
        rep.needed = keep;
        rep.lowest = low;
        rep.kept   = kept_total;
        rep.sel    = (int'(idx) < NUM_INPUTS) ? input_counts[idx] : CNT_ZERO;
        return rep;
    endfunction

    // Check each accepted report against the oldest prediction
    always @(posedge clk)
    begin
        quota_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report: needed %0d lowest %0d kept %0d selected %0d",
                       needed, lowest_count, kept_events, selected_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (needed !== want.needed)
                begin
                    $error("needed: expected %0d, got %0d", want.needed, needed);
                    mismatch_count++;
                end
                if (lowest_count !== want.lowest)
                begin
                    $error("lowest_count: expected %0d, got %0d", want.lowest, lowest_count);
                    mismatch_count++;
                end
                if (kept_events !== want.kept)
                begin
                    $error("kept_events: expected %0d, got %0d", want.kept, kept_events);
                    mismatch_count++;
                end
                if (selected_count !== want.sel)
                begin
                    $error("selected_count: expected %0d, got %0d", want.sel, selected_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one item, idling at random first, and record its predicted report
    task automatic send_item(input cmd_t cmd, input logic [MASK_W-1:0] hdr,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        header_bits <= hdr;
        input_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_reports.push_back(count_item(cmd, hdr, idx));
    endtask

    // Drop valid, let every report arrive, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write a register, then read it back
    task automatic write_reg(input logic [REG_IDX_W-1:0] reg_idx,
                             input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] model_val;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_REQUESTED)
        begin
            quota_reg = value[CNT_W-1:0];
            model_val = DATA_W'(quota_reg);
        end
        else
        begin
            mask_reg  = value[MASK_W-1:0];
            model_val = DATA_W'(mask_reg);
        end
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = (reg_idx == REG_REQUESTED) ? DATA_W'(prdata[CNT_W-1:0])
                                              : DATA_W'(prdata[MASK_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== model_val)
        begin
            $error("prdata: expected %0d, got %0d", model_val, readback);
            mismatch_count++;
        end
    endtask

    // Header masks biased toward empty, full, single-input and all-but-one patterns
    function automatic logic [MASK_W-1:0] pick_mask();
        logic [MASK_W-1:0] one_hot;
        one_hot = '0;
        one_hot[$urandom_range(MASK_W - 1)] = 1'b1;
        case ($urandom_range(7))
            0:       return NO_INPUTS;
            1:       return ALL_INPUTS;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return MASK_W'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        return IDX_W'($urandom_range(SEL_N - 1));
    endfunction

    // Events, queries and reset while disarmed
    task automatic test_disarmed_events();
        wait_idle();
        write_reg(REG_REQUESTED, 32'd3);
        write_reg(REG_MASKED, 32'd0);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd0);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd15);
        send_item(CMD_QUERY, ALL_INPUTS, 4'd7);
        send_item(CMD_INIT, ALL_INPUTS, 4'd1);
        send_item(CMD_RESET, ALL_INPUTS, 4'd0);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd2);
        send_item(CMD_QUERY, NO_INPUTS, 4'd15);
    endtask

    // Quota reached per input, masked and empty inputs, extreme quotas
    task automatic test_quota_limits();
        wait_idle();
        write_reg(REG_REQUESTED, 32'd2);
        write_reg(REG_MASKED, 32'h0000_0001);
        send_item(CMD_INIT, ALL_INPUTS, 4'd0);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd1);
        send_item(CMD_EVENT, NO_INPUTS, 4'd1);
        send_item(CMD_EVENT, 15'h0001, 4'd0);
        send_item(CMD_EVENT, 15'h4000, 4'd14);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd14);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd1);
        send_item(CMD_EVENT, 15'h4000, 4'd14);
        send_item(CMD_QUERY, ALL_INPUTS, 4'd15);
        wait_idle();
        write_reg(REG_REQUESTED, DATA_W'(CNT_MAX));
        write_reg(REG_MASKED, 32'd0);
        send_item(CMD_INIT, 15'h5555, 4'd14);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd14);
        send_item(CMD_EVENT, 15'h0001, 4'd0);
        wait_idle();
        write_reg(REG_REQUESTED, 32'd0);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd0);
    endtask

    // Every input excluded by the mask or by the live set
    task automatic test_excluded_inputs();
        wait_idle();
        write_reg(REG_REQUESTED, 32'd1);
        write_reg(REG_MASKED, DATA_W'(ALL_INPUTS));
        send_item(CMD_INIT, ALL_INPUTS, 4'd3);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd3);
        wait_idle();
        write_reg(REG_MASKED, 32'd0);
        send_item(CMD_INIT, NO_INPUTS, 4'd4);
        send_item(CMD_EVENT, ALL_INPUTS, 4'd4);
        send_item(CMD_INIT, 15'h0001, 4'd1);
        send_item(CMD_EVENT, 15'h0002, 4'd1);
    endtask

    // One setting: runs of initialize followed by events, with stray commands
    task automatic run_phase(input int n_items, input cnt_t quota,
                             input logic [MASK_W-1:0] mask,
                             input int idle_pct, input int stall_pct);
        int sent;
        int run_len;
        int pick;
        wait_idle();
        write_reg(REG_REQUESTED, DATA_W'(quota));
        write_reg(REG_MASKED, DATA_W'(mask));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            // stray command between runs
            if ($urandom_range(9) == 0)
            begin
                send_item(cmd_t'($urandom_range(3)), MASK_W'($urandom), pick_index());
                sent++;
            end
            send_item(CMD_INIT, pick_mask(), pick_index());
            run_len = $urandom_range(4, 60);
            repeat (run_len)
            begin
                pick = $urandom_range(19);
                if (pick == 0)
                    send_item(CMD_QUERY, MASK_W'($urandom), pick_index());
                else if (pick == 1)
                    send_item(CMD_RESET, MASK_W'($urandom), pick_index());
                else
                    send_item(CMD_EVENT, pick_mask(), pick_index());
            end
            sent += run_len + 1;
        end
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Random traffic over several settings and idling patterns
    task automatic test_random_traffic();
        run_phase(300, cnt_t'(5), NO_INPUTS, 0, 0);
        run_phase(300, cnt_t'($urandom_range(1, 30)), MASK_W'($urandom), 80, 0);
        run_phase(150, CNT_MAX, ALL_INPUTS, 0, 80);
        run_phase(150, CNT_ZERO, MASK_W'($urandom), 21, 21);
        run_phase(300, cnt_t'($urandom_range(1, 30)), MASK_W'($urandom), 21, 21);
        run_phase(250, cnt_t'(3), 15'h0001 << $urandom_range(MASK_W - 1), 0, 80);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_INPUTS; i++)
            input_counts[i] = CNT_ZERO;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disarmed_events();
        test_quota_limits();
        test_excluded_inputs();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pieqf_pkg.sv
hw/rtl/pieqf_lane.sv
hw/rtl/pieqf_merge.sv
hw/rtl/per_input_event_quota_filter.sv
dv/tb_top.sv
